@@ design/bounded_xoshiro256pp_rng_defines.svh @@
// Assertion macros used by the bounded xoshiro256++ generator top level.
`ifndef BOUNDED_XOSHIRO256PP_RNG_DEFINES_SVH
`define BOUNDED_XOSHIRO256PP_RNG_DEFINES_SVH
`ifndef SYNTH
// Implication checked on every clock edge outside reset.
`define BXR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Plain condition checked on every clock edge outside reset.
`define BXR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define BXR_ASSERT_IMP(lbl, ante, cons, msg)
`define BXR_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

@@ design/bxr_pkg.sv @@
// Shared types and constants of the bounded xoshiro256++ generator.
package bxr_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_W  = 1;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] RANGE_RESET = 64'd32768;

  localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEED1 = 2'd1;
  localparam logic [OP_W-1:0] OP_SEED4 = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  localparam logic [CFG_W-1:0] REG_RANGE  = 1'b0;
  localparam logic [CFG_W-1:0] REG_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_SEED_WAIT,
    S_FIX,
    S_LIMIT,
    S_DRAW,
    S_MOD,
    S_DONE
  } bxr_state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } bxr_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] rem;
  } bxr_div_rsp_t;

endpackage

@@ design/bounded_xoshiro256pp_rng.sv @@
// Top level of the bounded xoshiro256++ generator: sequencer, state, config and output register.
//
// Bounded xoshiro256++ random source. A draw transaction (op 0) returns
// offset + a uniform value below range_size; range_size 0 gives the raw
// 64-bit output and a power-of-two range masks it. Any other range
// rejects raw outputs below (2^64 - range) mod range and reduces the
// accepted one modulo range, using one shared restoring remainder unit;
// the rejection limit is computed once after each write of range_size and
// then cached. Seed transactions (op 1: splitmix64 chain from word0; op 2:
// finalizer over word0..word3) give no result; the mixer's single 32x32
// multiplier needs six passes per word. Op 3 is taken and dropped.
// in_stall stays high while a transaction is in progress; a finished
// result waits in the output register so the next transaction can be
// taken. Write configuration only while the block is idle.
`include "bounded_xoshiro256pp_rng_defines.svh"
module bounded_xoshiro256pp_rng (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bxr_pkg::OP_W-1:0]   in_op,
  input  logic [bxr_pkg::WORD_W-1:0] in_word0,
  input  logic [bxr_pkg::WORD_W-1:0] in_word1,
  input  logic [bxr_pkg::WORD_W-1:0] in_word2,
  input  logic [bxr_pkg::WORD_W-1:0] in_word3,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bxr_pkg::WORD_W-1:0] out_value,
  input  logic                       cfg_we,
  input  logic [bxr_pkg::CFG_W-1:0]  cfg_index,
  input  logic [bxr_pkg::WORD_W-1:0] cfg_wdata
);
  import bxr_pkg::*;

  bxr_state_t        state_r, state_nxt;
  logic [WORD_W-1:0] st_r [4];
  logic [WORD_W-1:0] st_nxt [4];
  logic [WORD_W-1:0] w_r [4];
  logic [WORD_W-1:0] chain_r, chain_nxt;
  logic              seed1_r, seed1_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [WORD_W-1:0] range_r, offset_r;
  logic [WORD_W-1:0] lim_r, lim_nxt;
  logic              lim_ok_r, lim_ok_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;

  logic              accept;
  logic              range_zero, range_pow2;
  logic [WORD_W-1:0] adv_sum, adv_res, adv_t;
  logic [WORD_W-1:0] a0, a1, a2, a3;
  logic [WORD_W-1:0] seed_z;
  logic              mix_start, mix_done;
  logic [WORD_W-1:0] mix_res;
  bxr_div_req_t      div_req;
  bxr_div_rsp_t      div_rsp;

  bxr_mixer u_mixer (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mix_start),
    .z_in   (seed_z),
    .done   (mix_done),
    .result (mix_res)
  );

  bxr_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign range_zero = (range_r == '0);
  assign range_pow2 = ((range_r & (range_r - 1'b1)) == '0);

  // One xoshiro256++ step on the current state.
  always_comb begin
    adv_sum = st_r[0] + st_r[3];
    adv_res = {adv_sum[40:0], adv_sum[63:41]} + st_r[0];
    adv_t   = st_r[1] << 17;
    a2      = st_r[2] ^ st_r[0];
    a3      = st_r[3] ^ st_r[1];
    a1      = st_r[1] ^ a2;
    a0      = st_r[0] ^ a3;
  end

  // Next splitmix64 input: chain value for single-value seeding, own word otherwise.
  assign seed_z = (seed1_r ? chain_r : w_r[idx_r]) + GOLDEN_STEP;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    chain_nxt     = chain_r;
    seed1_nxt     = seed1_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    lim_ok_nxt    = lim_ok_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    mix_start     = 1'b0;
    div_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_DRAW: begin
              if (range_zero || range_pow2 || lim_ok_r) begin
                state_nxt = S_DRAW;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = '0 - range_r;
                div_req.divisor  = range_r;
                state_nxt        = S_LIMIT;
              end
            end
            OP_SEED1, OP_SEED4: begin
              seed1_nxt = (in_op == OP_SEED1);
              chain_nxt = in_word0;
              idx_nxt   = 2'd0;
              state_nxt = S_SEED;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEED: begin
        mix_start = 1'b1;
        chain_nxt = seed_z;
        state_nxt = S_SEED_WAIT;
      end
      S_SEED_WAIT: begin
        if (mix_done) begin
          st_nxt[idx_r] = mix_res;
          idx_nxt       = idx_r + 2'd1;
          state_nxt     = (idx_r == 2'd3) ? S_FIX : S_SEED;
        end
      end
      S_FIX: begin
        // An all-zero state would lock up the generator; restore the reset word.
        if ((st_r[0] | st_r[1] | st_r[2] | st_r[3]) == '0) begin
          st_nxt[0] = GOLDEN_STEP;
        end
        state_nxt = S_IDLE;
      end
      S_LIMIT: begin
        if (div_rsp.done) begin
          lim_nxt    = div_rsp.rem;
          lim_ok_nxt = 1'b1;
          state_nxt  = S_DRAW;
        end
      end
      S_DRAW: begin
        st_nxt[0] = a0;
        st_nxt[1] = a1;
        st_nxt[2] = a2 ^ adv_t;
        st_nxt[3] = {a3[18:0], a3[63:19]};
        if (range_zero) begin
          res_nxt   = adv_res;
          state_nxt = S_DONE;
        end else if (range_pow2) begin
          res_nxt   = adv_res & (range_r - 1'b1);
          state_nxt = S_DONE;
        end else if (adv_res >= lim_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = adv_res;
          div_req.divisor  = range_r;
          state_nxt        = S_MOD;
        end
        // Below the limit: stay and advance again.
      end
      S_MOD: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = offset_r + res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A new range invalidates the cached rejection limit.
    if (cfg_we && cfg_index == REG_RANGE) begin
      lim_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r[0]     <= GOLDEN_STEP;
      st_r[1]     <= '0;
      st_r[2]     <= '0;
      st_r[3]     <= '0;
      range_r     <= RANGE_RESET;
      offset_r    <= '0;
      lim_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      seed1_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      lim_ok_r    <= lim_ok_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      seed1_r     <= seed1_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE:  range_r  <= cfg_wdata;
          REG_OFFSET: offset_r <= cfg_wdata;
          default:    range_r  <= range_r;
        endcase
      end
    end
    if (accept) begin
      w_r[0] <= in_word0;
      w_r[1] <= in_word1;
      w_r[2] <= in_word2;
      w_r[3] <= in_word3;
    end
    chain_r     <= chain_nxt;
    lim_r       <= lim_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `BXR_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r == S_DONE), "result without finished draw")
  `BXR_ASSERT_IMP(a_idle_nonzero, state_r == S_IDLE, (st_r[0] | st_r[1] | st_r[2] | st_r[3]) != '0, "all-zero generator state")
  `BXR_ASSERT_IMP(a_mix_div_excl, mix_start, !div_rsp.busy, "mixer and divider both active")

endmodule

@@ design/bxr_divider.sv @@
// Restoring remainder unit: one quotient bit per cycle.
module bxr_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bxr_pkg::bxr_div_req_t req,
  output bxr_pkg::bxr_div_rsp_t rsp
);
  import bxr_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] div_r, div_nxt;
  logic [WORD_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[WORD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = WORD_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[WORD_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ design/bxr_mixer.sv @@
// Splitmix64 finalizer built on one shared 32x32 multiplier, three partial products per 64-bit product.
module bxr_mixer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bxr_pkg::WORD_W-1:0] z_in,
  output logic                       done,
  output logic [bxr_pkg::WORD_W-1:0] result
);
  import bxr_pkg::*;

  localparam int unsigned HALF = WORD_W / 2;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              phase_r, phase_nxt;
  logic [1:0]        part_r, part_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] cst;
  logic [HALF-1:0]   opa, opb;
  logic [WORD_W-1:0] prod;

  always_comb begin
    cst = phase_r ? MIX_MUL_B : MIX_MUL_A;
    case (part_r)
      2'd0:    begin opa = a_r[HALF-1:0];      opb = cst[HALF-1:0];      end
      2'd1:    begin opa = a_r[WORD_W-1:HALF]; opb = cst[HALF-1:0];      end
      default: begin opa = a_r[HALF-1:0];      opb = cst[WORD_W-1:HALF]; end
    endcase
    prod = WORD_W'(opa) * WORD_W'(opb);

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    part_nxt  = part_r;
    a_nxt     = a_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      part_nxt  = 2'd0;
      a_nxt     = z_in ^ (z_in >> 30);
    end else if (busy_r) begin
      if (part_r == 2'd0) begin
        acc_nxt = prod;
      end else begin
        acc_nxt = acc_r + {prod[HALF-1:0], {HALF{1'b0}}};
      end
      if (part_r == 2'd2) begin
        part_nxt = 2'd0;
        if (!phase_r) begin
          phase_nxt = 1'b1;
          a_nxt     = acc_nxt ^ (acc_nxt >> 27);
        end else begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = acc_nxt ^ (acc_nxt >> 31);
        end
      end else begin
        part_nxt = part_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      part_r  <= 2'd0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
    end
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
